// ===== hdl/spg_pkg.sv =====
// Shared types and constants for the stepper step pulse generator.
// Holds the transfer payload structs, mode and register codes, and divider widths.
// No dependencies.
`default_nettype none

package spg_pkg;

  // Number of motor channels that the fields and line vectors are sized for.
  localparam int NCH = 3;

  // Item modes.
  localparam logic [2:0] MODE_TICK_ALL    = 3'd0;
  localparam logic [2:0] MODE_TICK_ONE    = 3'd1;
  localparam logic [2:0] MODE_SET_SPEED   = 3'd2;
  localparam logic [2:0] MODE_SET_DIR     = 3'd3;
  localparam logic [2:0] MODE_ENABLE      = 3'd4;
  localparam logic [2:0] MODE_DISABLE     = 3'd5;
  localparam logic [2:0] MODE_ENABLE_ALL  = 3'd6;
  localparam logic [2:0] MODE_DISABLE_ALL = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
  localparam logic [2:0] REG_MIN_SPEED   = 3'd1;
  localparam logic [2:0] REG_USTEP_M0    = 3'd2;
  localparam logic [2:0] REG_USTEP_M1    = 3'd3;
  localparam logic [2:0] REG_USTEP_M2    = 3'd4;
  localparam logic [2:0] REG_DIR_POL     = 3'd5;

  // Period arithmetic: 100000 / (2 * microsteps * speed).
  localparam int Q_W   = 17;                 // dividend and quotient width
  localparam int MUL_W = 24;                 // 8 x 16 bit product
  localparam int DEN_W = MUL_W + 1;          // product times two
  localparam logic [Q_W-1:0] PERIOD_BASE = 17'd100000;

  // Input item.
  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  motor;
    logic [31:0] speed;
    logic        dir;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [2:0]  step_lines;
    logic [2:0]  dir_lines;
    logic [15:0] period_out;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/spg_div.sv =====
// Iterative restoring divider for the step period: PERIOD_BASE / divisor.
// One quotient bit per cycle, done pulses when the quotient is ready.
// Depends on spg_pkg.
`default_nettype none

module spg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [spg_pkg::DEN_W-1:0]   divisor,
  output logic                             done,
  output logic [spg_pkg::Q_W-1:0]          quotient
);

  localparam int CNT_W = $clog2(spg_pkg::Q_W);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [spg_pkg::DEN_W-1:0]   rem_r;
  logic [spg_pkg::Q_W-1:0]     acc_r;
  logic [spg_pkg::DEN_W-1:0]   den_r;

  logic [spg_pkg::DEN_W:0]     trial;
  logic [spg_pkg::DEN_W+1:0]   diff;
  logic                        neg;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial = {rem_r, acc_r[spg_pkg::Q_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_r};
    neg   = diff[spg_pkg::DEN_W+1];
  end

  // Control of the step sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(spg_pkg::Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      acc_r <= spg_pkg::PERIOD_BASE;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= neg ? trial[spg_pkg::DEN_W-1:0] : diff[spg_pkg::DEN_W-1:0];
      acc_r <= {acc_r[spg_pkg::Q_W-2:0], ~neg};
    end
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

`default_nettype wire

// ===== hdl/stepper_step_pulse_generator.sv =====
// Top level of the stepper step pulse generator: sequencer, motor state and config.
// Depends on spg_pkg and spg_div.
`default_nettype none

// Step/direction generator for up to three motors. Each accepted item ticks,
// configures, enables or disables motors and yields one result holding the
// step and direction line levels and the period of the addressed motor. All
// modes but a set speed of a valid motor with a nonzero speed finish in the
// accepting cycle, and their result appears in the output register the cycle
// after. Such a set speed runs one 8x16 multiply (S_MUL), starts the 17-step
// shared restoring divider (S_START) and waits in S_DIV until it is done; its
// result is registered when the divider is done, and no new item is taken
// before then. The input side is ready whenever the sequencer is idle and
// the output register is empty or being emptied.
module stepper_step_pulse_generator #(
  parameter int MOTORS = 3
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire spg_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output spg_pkg::out_t       out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_wdata
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MUL   = 2'd1;
  localparam logic [1:0] S_START = 2'd2;
  localparam logic [1:0] S_DIV   = 2'd3;

  // Configuration registers.
  logic [15:0]             max_speed_r;
  logic [15:0]             min_speed_r;
  logic [7:0]              ustep_r [spg_pkg::NCH];
  logic [spg_pkg::NCH-1:0] dir_pol_r;

  // Motor state.
  logic [15:0]       period_r  [MOTORS];
  logic [15:0]       period_nxt[MOTORS];
  logic [15:0]       count_r   [MOTORS];
  logic [15:0]       count_nxt [MOTORS];
  logic [MOTORS-1:0] enabled_r, enabled_nxt;
  logic [MOTORS-1:0] step_r, step_nxt;
  logic [MOTORS-1:0] dir_r, dir_nxt;

  // Sequencer and set speed operands.
  logic [1:0]                state_r, state_nxt;
  spg_pkg::in_t              item_r;
  logic [15:0]               speed_r;
  logic [7:0]                ustep_sel_r;
  logic [spg_pkg::MUL_W-1:0] prod_r;

  logic                      out_valid_r;
  spg_pkg::out_t             out_data_r;

  logic                      in_fire;
  logic                      long_op;
  logic                      commit;
  spg_pkg::in_t              cmd;
  spg_pkg::out_t             result;
  logic [15:0]               clamped;
  logic [7:0]                ustep_sel;
  logic                      div_done;
  logic [spg_pkg::Q_W-1:0]   quotient;
  logic [15:0]               new_period;
  logic                      cmd_valid;
  logic                      hit;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign long_op  = (in_data.mode == spg_pkg::MODE_SET_SPEED) &&
                    (in_data.motor < 3'(MOTORS)) && (in_data.speed != 32'd0);

  // Speed clamp: upper limit is tested first.
  always_comb begin
    if (in_data.speed > {16'd0, max_speed_r}) begin
      clamped = max_speed_r;
    end else if (in_data.speed < {16'd0, min_speed_r}) begin
      clamped = min_speed_r;
    end else begin
      clamped = in_data.speed[15:0];
    end
  end

  // Microstep factor of the addressed motor.
  always_comb begin
    ustep_sel = '0;
    for (int i = 0; i < spg_pkg::NCH; i++) begin
      if (in_data.motor == 3'(i)) begin
        ustep_sel = ustep_r[i];
      end
    end
  end

  // Shared divider; a zero divisor yields all ones and saturates.
  spg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_START),
    .divisor  ({prod_r, 1'b0}),
    .done     (div_done),
    .quotient (quotient)
  );

  assign new_period = div_done ?
                      (quotient[spg_pkg::Q_W-1] ? 16'hFFFF : quotient[15:0]) : 16'd0;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire && long_op) begin
                 state_nxt = S_MUL;
               end
      S_MUL:   state_nxt = S_START;
      S_START: state_nxt = S_DIV;
      S_DIV:   if (div_done) begin
                 state_nxt = S_IDLE;
               end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Item execution: immediate items at acceptance, computed set speed at divider completion.
  assign cmd    = div_done ? item_r : in_data;
  assign commit = div_done || (in_fire && !long_op);

  always_comb begin
    period_nxt  = period_r;
    count_nxt   = count_r;
    enabled_nxt = enabled_r;
    step_nxt    = step_r;
    dir_nxt     = dir_r;
    hit         = 1'b0;
    if (commit) begin
      for (int i = 0; i < MOTORS; i++) begin
        hit = (cmd.motor == 3'(i));
        unique case (cmd.mode) inside
          spg_pkg::MODE_TICK_ALL, spg_pkg::MODE_TICK_ONE: begin
            if ((cmd.mode == spg_pkg::MODE_TICK_ALL || hit) &&
                period_r[i] != 16'd0 && enabled_r[i]) begin
              if (count_r[i] + 16'd1 == period_r[i]) begin
                count_nxt[i] = 16'd0;
                step_nxt[i]  = ~step_r[i];
              end else begin
                count_nxt[i] = count_r[i] + 16'd1;
              end
            end
          end
          spg_pkg::MODE_SET_SPEED: if (hit) begin
            period_nxt[i] = new_period;
          end
          spg_pkg::MODE_SET_DIR: if (hit) begin
            dir_nxt[i] = cmd.dir ? dir_pol_r[i] : ~dir_pol_r[i];
          end
          spg_pkg::MODE_ENABLE: if (hit) begin
            enabled_nxt[i] = 1'b1;
          end
          spg_pkg::MODE_DISABLE: if (hit) begin
            enabled_nxt[i] = 1'b0;
          end
          spg_pkg::MODE_ENABLE_ALL:  enabled_nxt[i] = 1'b1;
          spg_pkg::MODE_DISABLE_ALL: enabled_nxt[i] = 1'b0;
          default: ;
        endcase
      end
    end
  end

  // Result from the state after this item.
  always_comb begin
    result    = '0;
    cmd_valid = (cmd.motor < 3'(MOTORS));
    for (int i = 0; i < MOTORS; i++) begin
      result.step_lines[i] = step_nxt[i];
      result.dir_lines[i]  = dir_nxt[i];
      if (cmd_valid && cmd.motor == 3'(i)) begin
        result.period_out = period_nxt[i];
      end
    end
  end

  // Control, motor state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      enabled_r   <= '0;
      step_r      <= '0;
      dir_r       <= '0;
      for (int i = 0; i < MOTORS; i++) begin
        period_r[i] <= 16'd0;
        count_r[i]  <= 16'd0;
      end
      max_speed_r <= 16'd500;
      min_speed_r <= 16'd1;
      ustep_r[0]  <= 8'd16;
      ustep_r[1]  <= 8'd32;
      ustep_r[2]  <= 8'd8;
      dir_pol_r   <= 3'd7;
    end else begin
      state_r   <= state_nxt;
      enabled_r <= enabled_nxt;
      step_r    <= step_nxt;
      dir_r     <= dir_nxt;
      period_r  <= period_nxt;
      count_r   <= count_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          spg_pkg::REG_MAX_SPEED: max_speed_r <= cfg_wdata;
          spg_pkg::REG_MIN_SPEED: min_speed_r <= cfg_wdata;
          spg_pkg::REG_USTEP_M0:  ustep_r[0]  <= cfg_wdata[7:0];
          spg_pkg::REG_USTEP_M1:  ustep_r[1]  <= cfg_wdata[7:0];
          spg_pkg::REG_USTEP_M2:  ustep_r[2]  <= cfg_wdata[7:0];
          spg_pkg::REG_DIR_POL:   dir_pol_r   <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (commit) begin
      out_data_r <= result;
    end
    if (in_fire) begin
      item_r      <= in_data;
      speed_r     <= clamped;
      ustep_sel_r <= ustep_sel;
    end
    if (state_r == S_MUL) begin
      prod_r <= ustep_sel_r * speed_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/spg_checker.sv =====
// Port-level checks for the stepper step pulse generator, bound to the top level.
// Depends on spg_pkg and stepper_step_pulse_generator.
`default_nettype none

module spg_port_checks #(
  parameter int MOTORS = 3
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire spg_pkg::in_t  in_data,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire spg_pkg::out_t out_data
);

  // A waiting result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped before transfer");

  // Reset leaves the output register empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Immediate modes deliver their result in the next cycle.
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !(in_data.mode == spg_pkg::MODE_SET_SPEED) |=> out_valid)
    else $error("immediate item gave no result");

  // A computed set speed keeps the input side busy.
  a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.mode == spg_pkg::MODE_SET_SPEED &&
    in_data.motor < 3'(MOTORS) && in_data.speed != 32'd0 |=> !in_ready && !out_valid)
    else $error("input accepted during period computation");

  // No transfer in while a result is stuck at the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid || out_ready)
    else $error("ready while output register is full");

endmodule

bind stepper_step_pulse_generator spg_port_checks #(.MOTORS(MOTORS)) u_spg_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
